// File: rtl/lhv_pkg.sv
// Shared constants, types and helper functions for the local host name validator.
package lhv_pkg;

    localparam int MAX_NAME_LEN  = 253;
    localparam int MAX_LABEL_LEN = 63;

    localparam int CHAR_W   = 8;
    localparam int TOTAL_W  = 8;
    localparam int LABEL_W  = 7;
    localparam int SUFFIX_N = 6;
    localparam int TAIL_W   = SUFFIX_N * CHAR_W;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;

    localparam logic [TAIL_W-1:0]  SUFFIX_LOCAL = 48'h2E6C6F63616C;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT    = '1;
    localparam logic [LABEL_W-1:0] LABEL_SAT    = '1;

    typedef struct packed {
        logic              step;
        logic [CHAR_W-1:0] char_byte;
    } lhv_step_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || is_upper(c) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? (c | 8'h20) : c;
    endfunction

endpackage

// File: rtl/lhv_if.sv
// Valid/ready channel interfaces for name bytes and verdicts.
interface lhv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface lhv_verdict_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source (output valid, output name_valid, input ready);
    modport sink   (input valid, input name_valid, output ready);
endinterface

// File: rtl/lhv_scan.sv
// Per-name scan state: counters, label flags, tail bytes and verdict logic.
module lhv_scan
    import lhv_pkg::*;
#(
    parameter int NAME_LEN_MAX  = MAX_NAME_LEN,
    parameter int LABEL_LEN_MAX = MAX_LABEL_LEN
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  lhv_step_t step_in,
    output logic      verdict
);

    logic [TOTAL_W-1:0] total_count_reg, total_count_next;
    logic [LABEL_W-1:0] label_count_reg, label_count_next;
    logic               starts_hyphen_reg, starts_hyphen_next;
    logic               prev_hyphen_reg, prev_hyphen_next;
    logic               bad_char_reg, bad_char_next;
    logic               bad_label_reg, bad_label_next;
    logic               dot_seen_reg, dot_seen_next;
    logic [TAIL_W-1:0]  tail_reg, tail_next;

    logic [CHAR_W-1:0]  c;
    logic               is_nul;
    logic               is_dot;
    logic               is_hyphen;
    logic               label_bad;
    logic               len_ok;
    logic               suffix_ok;

    assign c         = step_in.char_byte;
    assign is_nul    = (c == CHAR_NUL);
    assign is_dot    = (c == CHAR_DOT);
    assign is_hyphen = (c == CHAR_HYPHEN);

    assign label_bad = (label_count_reg == '0) ||
                       (label_count_reg > LABEL_W'(LABEL_LEN_MAX)) ||
                       starts_hyphen_reg || prev_hyphen_reg;
    assign len_ok    = (total_count_reg != '0) &&
                       (total_count_reg <= TOTAL_W'(NAME_LEN_MAX));
    assign suffix_ok = (total_count_reg > TOTAL_W'(SUFFIX_N)) &&
                       (tail_reg == SUFFIX_LOCAL);
    assign verdict   = len_ok && !bad_char_reg && !bad_label_reg && !label_bad &&
                       (!dot_seen_reg || suffix_ok);

    always_comb
    begin
        total_count_next   = total_count_reg;
        label_count_next   = label_count_reg;
        starts_hyphen_next = starts_hyphen_reg;
        prev_hyphen_next   = prev_hyphen_reg;
        bad_char_next      = bad_char_reg;
        bad_label_next     = bad_label_reg;
        dot_seen_next      = dot_seen_reg;
        tail_next          = tail_reg;
        if (step_in.step)
        begin
            if (is_nul)
            begin
                total_count_next   = '0;
                label_count_next   = '0;
                starts_hyphen_next = 1'b0;
                prev_hyphen_next   = 1'b0;
                bad_char_next      = 1'b0;
                bad_label_next     = 1'b0;
                dot_seen_next      = 1'b0;
                tail_next          = '0;
            end
            else
            begin
                if (total_count_reg != TOTAL_SAT)
                begin
                    total_count_next = total_count_reg + TOTAL_W'(1);
                end
                tail_next = {tail_reg[TAIL_W-CHAR_W-1:0], to_lower(c)};
                if (is_dot)
                begin
                    dot_seen_next      = 1'b1;
                    bad_label_next     = bad_label_reg | label_bad;
                    label_count_next   = '0;
                    starts_hyphen_next = 1'b0;
                    prev_hyphen_next   = 1'b0;
                end
                else
                begin
                    bad_char_next = bad_char_reg | !(is_alnum(c) || is_hyphen);
                    if ((label_count_reg == '0) && is_hyphen)
                    begin
                        starts_hyphen_next = 1'b1;
                    end
                    prev_hyphen_next = is_hyphen;
                    if (label_count_reg != LABEL_SAT)
                    begin
                        label_count_next = label_count_reg + LABEL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg   <= '0;
            label_count_reg   <= '0;
            starts_hyphen_reg <= 1'b0;
            prev_hyphen_reg   <= 1'b0;
            bad_char_reg      <= 1'b0;
            bad_label_reg     <= 1'b0;
            dot_seen_reg      <= 1'b0;
            tail_reg          <= '0;
        end
        else
        begin
            total_count_reg   <= total_count_next;
            label_count_reg   <= label_count_next;
            starts_hyphen_reg <= starts_hyphen_next;
            prev_hyphen_reg   <= prev_hyphen_next;
            bad_char_reg      <= bad_char_next;
            bad_label_reg     <= bad_label_next;
            dot_seen_reg      <= dot_seen_next;
            tail_reg          <= tail_next;
        end
    end

    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (step_in.step && is_nul) |=>
            (total_count_reg == '0) && (label_count_reg == '0) && !dot_seen_reg)
        else $error("scan state not cleared after end of name");

    a_label_flags_reset_on_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (step_in.step && is_dot) |=>
            (label_count_reg == '0) && !starts_hyphen_reg && !prev_hyphen_reg)
        else $error("label state not cleared at dot");

endmodule

// File: rtl/local_hostname_validator.sv
// Top level of the local host name validator: input word register, scan, verdict register.
//
//   channel      dir  payload          width
//   char_chan    in   char_byte        8
//   verdict_chan out  name_valid       1
//
// One word per cycle while no zero word waits on a stalled verdict; a verdict is
// registered once its zero word leaves the input word register. rst_n clears all scan state
// and both valid flags.
// A stalled verdict holds only zero words; other words keep flowing into the
// scan state while the verdict waits.
module local_hostname_validator
    import lhv_pkg::*;
#(
    parameter int NAME_LEN_MAX  = MAX_NAME_LEN,
    parameter int LABEL_LEN_MAX = MAX_LABEL_LEN
)
(
    input  logic          clk,
    input  logic          rst_n,
    lhv_byte_if.sink      char_chan,
    lhv_verdict_if.source verdict_chan
);

    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_byte_reg;
    logic              out_vld_reg, out_vld_next;
    logic              out_bit_reg;
    logic              advance;
    logic              end_word;
    logic              verdict;
    lhv_step_t         step;

    assign end_word = (in_byte_reg == CHAR_NUL);
    assign advance  = in_vld_reg && (!end_word || !out_vld_reg || verdict_chan.ready);

    assign char_chan.ready         = !in_vld_reg || advance;
    assign verdict_chan.valid      = out_vld_reg;
    assign verdict_chan.name_valid = out_bit_reg;

    assign step.step      = advance;
    assign step.char_byte = in_byte_reg;

    lhv_scan #(
        .NAME_LEN_MAX  (NAME_LEN_MAX),
        .LABEL_LEN_MAX (LABEL_LEN_MAX)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_in (step),
        .verdict (verdict)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg && !verdict_chan.ready;
        if (advance && end_word)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (char_chan.ready)
            begin
                in_vld_reg <= char_chan.valid;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            in_byte_reg <= char_chan.char_byte;
        end
        if (advance && end_word)
        begin
            out_bit_reg <= verdict;
        end
    end

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("input word lost while stalled");

    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && end_word) |=> out_vld_reg)
        else $error("end of name did not produce a verdict");

    a_no_spurious_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_vld_reg && !(advance && end_word)) |=> !out_vld_reg)
        else $error("verdict without end of name");

    a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |-> (end_word && out_vld_reg))
        else $error("non-terminating word stalled");

endmodule
